@@ rtl/two_class_age_ordered_queue_assert.svh @@
// ----------------------------------------------------------------------------
// two class age ordered queue assertion macros
// shared wrappers for the concurrent checks of the block
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_AGE_ORDERED_QUEUE_ASSERT_SVH
`define TWO_CLASS_AGE_ORDERED_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TCAOQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcaoq check failed");

// next-cycle implication
`define TCAOQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcaoq check failed");

`else

`define TCAOQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TCAOQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/tcaoq_pkg.sv @@
// ----------------------------------------------------------------------------
// tcaoq_pkg
// shared constants, operation and status codes for the two class queue
// ----------------------------------------------------------------------------
package tcaoq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TAG_BITS    = 16;
    localparam int DEF_SEQ_BITS    = 16;

    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int TAG_FIELD_W = 16;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ENQ_A   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ENQ_B   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ENQ_BAD = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEQ_ANY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEQ_A   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DEQ_B   = 3'd5;

    // result status
    localparam logic [STATUS_W-1:0] ST_ENQ     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DEQ     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;

    // per-fifo command
    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

endpackage

@@ rtl/two_class_age_ordered_queue.sv @@
// ----------------------------------------------------------------------------
// two_class_age_ordered_queue
// oldest-first queue over two class fifos with a shared arrival sequence
// ----------------------------------------------------------------------------
// s_axis carries one request per beat: tuser is the kind (enqueue a, enqueue b,
//   enqueue with bad class, dequeue any, dequeue a, dequeue b), tdata the tag
// m_axis returns exactly one result per request: tuser is the status, tdata
//   the dequeued tag and its class; every enqueue kind takes a sequence number
// dequeue any pops whichever head carries the older sequence number
// path: a request accepted on s_axis is registered in the request stage, processed
//   there, and its result is held in the result register that drives m_axis
// throughput: one request per cycle while m_axis does not stall, set by the single
//   pass from the request register through the fifo head compare into the result register
// reset: both fifos empty, sequence counter zero; storage is not cleared
// stall: when m_axis_tready is low the result holds, the request stage fills
//   and s_axis_tready drops until the receiver takes the result
// ----------------------------------------------------------------------------
`include "two_class_age_ordered_queue_assert.svh"

module two_class_age_ordered_queue
    import tcaoq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TAG_BITS    = DEF_TAG_BITS,
    parameter int SEQ_BITS    = DEF_SEQ_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TAG_FIELD_W-1:0] s_axis_tdata,   // [15:0] item_tag
    input  logic [KIND_W-1:0]      s_axis_tuser,   // [2:0] kind
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [23:0]            m_axis_tdata,   // [15:0] out_tag, [16] out_class, rest zero
    output logic [STATUS_W-1:0]    m_axis_tuser    // [2:0] status
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // request stage
    logic                   s1_valid_reg;
    logic [KIND_W-1:0]      s1_kind_reg;
    logic [TAG_FIELD_W-1:0] s1_tag_reg;
    logic                   s1_fire;

    // arrival sequence
    logic [SEQ_BITS-1:0]    seq_reg;
    logic [SEQ_BITS-1:0]    seq_next;

    // result register
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [TAG_FIELD_W-1:0] out_tag_reg;
    logic                   out_class_reg;

    // fifo side
    fifo_ctrl_t             ctrl_a;
    fifo_ctrl_t             ctrl_b;
    logic [TAG_BITS-1:0]    wr_tag;
    logic [TAG_BITS-1:0]    head_tag_a;
    logic [TAG_BITS-1:0]    head_tag_b;
    logic [SEQ_BITS-1:0]    head_seq_a;
    logic [SEQ_BITS-1:0]    head_seq_b;
    logic [SEQ_BITS-1:0]    seq_diff;
    logic [CNT_W-1:0]       count_a;
    logic [CNT_W-1:0]       count_b;
    logic                   full_a;
    logic                   full_b;

    // result of the current request
    logic [STATUS_W-1:0]    res_status;
    logic [TAG_FIELD_W-1:0] res_tag;
    logic                   res_class;
    logic                   take_a;

    // handshakes
    assign s1_fire       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_fire;

    assign wr_tag   = TAG_BITS'(s1_tag_reg);
    assign full_a   = (count_a == CNT_W'(QUEUE_DEPTH));
    assign full_b   = (count_b == CNT_W'(QUEUE_DEPTH));
    // a is older when the wrapped difference is negative
    assign seq_diff = head_seq_a - head_seq_b;

    always_comb
    begin
        res_status = ST_EMPTY;
        res_tag    = '0;
        res_class  = 1'b0;
        ctrl_a     = '0;
        ctrl_b     = '0;
        seq_next   = seq_reg;
        take_a     = 1'b0;
        if (s1_fire)
        begin
            unique case (s1_kind_reg) inside
                KIND_ENQ_A:
                begin
                    seq_next = seq_reg + 1'b1;
                    if (full_a)
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        res_status  = ST_ENQ;
                        ctrl_a.push = 1'b1;
                    end
                end
                KIND_ENQ_B:
                begin
                    seq_next = seq_reg + 1'b1;
                    if (full_b)
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        res_status  = ST_ENQ;
                        ctrl_b.push = 1'b1;
                    end
                end
                KIND_DEQ_ANY, KIND_DEQ_A, KIND_DEQ_B:
                begin
                    if (s1_kind_reg == KIND_DEQ_A)
                    begin
                        take_a = 1'b1;
                    end
                    else if (s1_kind_reg == KIND_DEQ_B || count_a == '0)
                    begin
                        take_a = 1'b0;
                    end
                    else if (count_b == '0)
                    begin
                        take_a = 1'b1;
                    end
                    else
                    begin
                        take_a = seq_diff[SEQ_BITS-1];
                    end

                    if (take_a && count_a != '0)
                    begin
                        res_status = ST_DEQ;
                        res_tag    = TAG_FIELD_W'(head_tag_a);
                        ctrl_a.pop = 1'b1;
                    end
                    else if (!take_a && count_b != '0)
                    begin
                        res_status = ST_DEQ;
                        res_tag    = TAG_FIELD_W'(head_tag_b);
                        res_class  = 1'b1;
                        ctrl_b.pop = 1'b1;
                    end
                end
                default:
                begin
                    // bad class and unused kinds: take a number, store nothing
                    seq_next   = seq_reg + 1'b1;
                    res_status = ST_INVALID;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seq_reg       <= '0;
        end
        else
        begin
            seq_reg <= seq_next;
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            s1_kind_reg <= s_axis_tuser;
            s1_tag_reg  <= s_axis_tdata;
        end
        if (s1_fire)
        begin
            out_status_reg <= res_status;
            out_tag_reg    <= res_tag;
            out_class_reg  <= res_class;
        end
    end

    tcaoq_fifo #(
        .DEPTH    (QUEUE_DEPTH),
        .TAG_BITS (TAG_BITS),
        .SEQ_BITS (SEQ_BITS)
    ) u_fifo_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl_a),
        .wr_tag   (wr_tag),
        .wr_seq   (seq_reg),
        .head_tag (head_tag_a),
        .head_seq (head_seq_a),
        .count    (count_a)
    );

    tcaoq_fifo #(
        .DEPTH    (QUEUE_DEPTH),
        .TAG_BITS (TAG_BITS),
        .SEQ_BITS (SEQ_BITS)
    ) u_fifo_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl_b),
        .wr_tag   (wr_tag),
        .wr_seq   (seq_reg),
        .head_tag (head_tag_b),
        .head_seq (head_seq_b),
        .count    (count_b)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {7'd0, out_class_reg, out_tag_reg};

    `TCAOQ_ASSERT_IMPLY(a_one_fifo_moves, clk, rst_n, ctrl_a.push || ctrl_a.pop,
        !(ctrl_b.push || ctrl_b.pop))
    `TCAOQ_ASSERT_NEXT(a_seq_idle, clk, rst_n, !s1_fire, seq_reg == $past(seq_reg))
    `TCAOQ_ASSERT_IMPLY(a_clean_nodeq, clk, rst_n, out_valid_reg && out_status_reg != ST_DEQ,
        out_tag_reg == '0 && !out_class_reg)

endmodule

@@ rtl/tcaoq_fifo.sv @@
// ----------------------------------------------------------------------------
// tcaoq_fifo
// one class fifo of {tag, sequence} entries with a registered head read
// ----------------------------------------------------------------------------
`include "two_class_age_ordered_queue_assert.svh"

module tcaoq_fifo
    import tcaoq_pkg::*;
#(
    parameter int DEPTH    = DEF_QUEUE_DEPTH,
    parameter int TAG_BITS = DEF_TAG_BITS,
    parameter int SEQ_BITS = DEF_SEQ_BITS,
    localparam int CNT_W   = $clog2(DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  fifo_ctrl_t          ctrl,
    input  logic [TAG_BITS-1:0] wr_tag,
    input  logic [SEQ_BITS-1:0] wr_seq,
    output logic [TAG_BITS-1:0] head_tag,
    output logic [SEQ_BITS-1:0] head_seq,
    output logic [CNT_W-1:0]    count
);

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int SUM_W   = IDX_W + 1;
    localparam int ENTRY_W = TAG_BITS + SEQ_BITS;

    logic [ENTRY_W-1:0] mem [DEPTH];

    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   head_next;
    logic [IDX_W-1:0]   head_inc;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [SUM_W-1:0]   wr_sum;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] rd_reg;
    logic               byp_reg;
    logic [ENTRY_W-1:0] byp_data_reg;
    logic [ENTRY_W-1:0] head_entry;

    // tail slot, wrapped for any depth
    assign wr_sum  = {1'b0, head_reg} + SUM_W'(count_reg);
    assign wr_addr = (wr_sum >= SUM_W'(DEPTH)) ? IDX_W'(wr_sum - SUM_W'(DEPTH))
                                               : IDX_W'(wr_sum);

    assign head_inc  = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_next = ctrl.pop ? head_inc : head_reg;

    always_comb
    begin
        case ({ctrl.push, ctrl.pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            // write into the slot that becomes the head: memory read is stale
            byp_reg   <= ctrl.push && (wr_addr == head_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_addr] <= {wr_tag, wr_seq};
        end
        rd_reg       <= mem[head_next];
        byp_data_reg <= {wr_tag, wr_seq};
    end

    assign head_entry = byp_reg ? byp_data_reg : rd_reg;
    assign head_tag   = head_entry[ENTRY_W-1:SEQ_BITS];
    assign head_seq   = head_entry[SEQ_BITS-1:0];
    assign count      = count_reg;

    `TCAOQ_ASSERT_IMPLY(a_no_push_full, clk, rst_n, ctrl.push, count_reg != CNT_W'(DEPTH))
    `TCAOQ_ASSERT_IMPLY(a_no_pop_empty, clk, rst_n, ctrl.pop, count_reg != '0)
    `TCAOQ_ASSERT_NEXT(a_push_counts, clk, rst_n, ctrl.push && !ctrl.pop, count_reg == CNT_W'($past(count_reg) + 1'b1))

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for two_class_age_ordered_queue
// drives requests on s_axis and predicts every result from a local model of
// the two class fifos and the arrival sequence counter; each result taken
// from m_axis is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
module tb;
    import tcaoq_pkg::*;

    // kinds outside the documented set behave like a bad-class enqueue
    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    localparam bit CLASS_A = 1'b0;
    localparam bit CLASS_B = 1'b1;

    localparam int QD           = DEF_QUEUE_DEPTH;
    localparam int IDLE_PCT     = 26;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 8;

    // one stored entry of a class fifo
    typedef struct packed {
        logic [DEF_TAG_BITS-1:0] tag;
        logic [DEF_SEQ_BITS-1:0] seq;
    } slot_t;

    // one predicted result
    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [TAG_FIELD_W-1:0] tag;
        logic                   cls;
    } outcome_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [TAG_FIELD_W-1:0] s_axis_tdata;   // [15:0] item_tag
    logic [KIND_W-1:0]      s_axis_tuser;   // [2:0] kind
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [23:0]            m_axis_tdata;   // [15:0] out_tag, [16] out_class, rest zero
    logic [STATUS_W-1:0]    m_axis_tuser;   // [2:0] status

    // local copy of the queue state
    slot_t                   class_mem [2][QD];
    int                      class_head [2];
    int                      class_count [2];
    logic [DEF_SEQ_BITS-1:0] arrival_seq;

    // predicted results, oldest first
    outcome_t outcome_queue [$];

    int idle_pct;
    int mismatch_count;
    int cycle_count;

    two_class_age_ordered_queue i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // apply one accepted request to the local state and queue its result
    function automatic void predict_outcome(input logic [KIND_W-1:0] kind,
                                            input logic [TAG_FIELD_W-1:0] tag);
        outcome_t                res;
        logic [DEF_SEQ_BITS-1:0] age_gap;
        bit                      pick;
        int                      slot;
        res        = '0;
        res.status = ST_EMPTY;
        if (kind == KIND_DEQ_ANY || kind == KIND_DEQ_A || kind == KIND_DEQ_B)
        begin
            if (kind == KIND_DEQ_A)
                pick = CLASS_A;
            else if (kind == KIND_DEQ_B)
                pick = CLASS_B;
            else if (class_count[CLASS_A] == 0)
                pick = CLASS_B;
            else if (class_count[CLASS_B] == 0)
                pick = CLASS_A;
            else
            begin
                // class a wins when its head is older, modulo the counter width
                age_gap = class_mem[CLASS_A][class_head[CLASS_A]].seq
                        - class_mem[CLASS_B][class_head[CLASS_B]].seq;
                pick    = age_gap[DEF_SEQ_BITS-1] ? CLASS_A : CLASS_B;
            end
            if (class_count[pick] != 0)
            begin
                res.status        = ST_DEQ;
                res.tag           = class_mem[pick][class_head[pick]].tag;
                res.cls           = pick;
                class_head[pick]  = (class_head[pick] + 1) % QD;
                class_count[pick] = class_count[pick] - 1;
            end
        end
        else
        begin
            // every enqueue kind, rejected or not, takes a sequence number
            if (kind == KIND_ENQ_A || kind == KIND_ENQ_B)
            begin
                pick = (kind == KIND_ENQ_B) ? CLASS_B : CLASS_A;
                if (class_count[pick] >= QD)
                    res.status = ST_FULL;
                else
                begin
                    slot                      = (class_head[pick] + class_count[pick]) % QD;
                    class_mem[pick][slot].tag = tag;
                    class_mem[pick][slot].seq = arrival_seq;
                    class_count[pick]         = class_count[pick] + 1;
                    res.status                = ST_ENQ;
                end
            end
            else
                res.status = ST_INVALID;
            arrival_seq = arrival_seq + 1'b1;
        end
        outcome_queue.push_back(res);
    endfunction

    // ------------------------------------------------------------------------
    // result side: random backpressure and checking
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch in %s: expected %0h, got %0h", field, want, got);
    endtask

    always @(posedge clk)
    begin : check_result
        outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (outcome_queue.size() == 0)
                report_mismatch("result with nothing pending", 32'h0,
                                32'({m_axis_tuser, m_axis_tdata}));
            else
            begin
                want = outcome_queue.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(m_axis_tuser));
                if (m_axis_tdata[15:0] !== want.tag)
                    report_mismatch("out_tag", 32'(want.tag), 32'(m_axis_tdata[15:0]));
                if (m_axis_tdata[16] !== want.cls)
                    report_mismatch("out_class", 32'(want.cls), 32'(m_axis_tdata[16]));
                if (m_axis_tdata[23:17] !== 7'd0)
                    report_mismatch("tdata padding", 32'h0, 32'(m_axis_tdata[23:17]));
            end
        end
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[two_class_age_ordered_queue] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // valid stays high after acceptance so back-to-back requests need no
    // second assignment in the same step; idle cycles lower it
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [TAG_FIELD_W-1:0] tag);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tag;
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_outcome(kind, tag);
    endtask

    function automatic logic [TAG_FIELD_W-1:0] any_tag();
        return TAG_FIELD_W'($urandom_range(16'hFFFF));
    endfunction

    // one of the three kinds that are rejected with invalid class
    function automatic logic [KIND_W-1:0] bad_kind();
        case ($urandom_range(2))
            0:       return KIND_ENQ_BAD;
            1:       return KIND_SPARE_6;
            default: return KIND_SPARE_7;
        endcase
    endfunction

    // enqueue share in percent sets whether the fifos tend to fill or drain
    function automatic logic [KIND_W-1:0] pick_kind(input int enq_weight);
        int r;
        r = $urandom_range(99);
        if (r < enq_weight)
        begin
            if ($urandom_range(19) == 0)
                return bad_kind();
            return $urandom_range(1) ? KIND_ENQ_B : KIND_ENQ_A;
        end
        case ($urandom_range(3)) inside
            0, 1:    return KIND_DEQ_ANY;
            2:       return KIND_DEQ_A;
            default: return KIND_DEQ_B;
        endcase
    endfunction

    // random traffic in blocks of fill-heavy, balanced and drain-heavy mixes
    task automatic run_mix(input int n);
        int enq_weight;
        enq_weight = 50;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0:       enq_weight = 85;
                    1:       enq_weight = 50;
                    default: enq_weight = 15;
                endcase
            end
            send_request(pick_kind(enq_weight), any_tag());
        end
    endtask

    // rejected enqueues until the sequence counter reaches the given value
    task automatic pump_sequence(input logic [DEF_SEQ_BITS-1:0] target);
        while (arrival_seq < target)
            send_request(bad_kind(), any_tag());
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // every dequeue flavor on an empty queue
    task automatic test_empty_dequeues;
        send_request(KIND_DEQ_ANY, 16'hFFFF);
        send_request(KIND_DEQ_A, 16'h0000);
        send_request(KIND_DEQ_B, 16'hA5A5);
    endtask

    // extreme tags, all kinds, age order both ways, empty class pops
    task automatic test_basic_order;
        send_request(KIND_ENQ_A, 16'h0000);
        send_request(KIND_ENQ_B, 16'hFFFF);
        send_request(KIND_ENQ_BAD, 16'hAAAA);
        send_request(KIND_SPARE_6, 16'h5555);
        send_request(KIND_SPARE_7, 16'h1234);
        send_request(KIND_ENQ_B, 16'h5555);
        send_request(KIND_ENQ_A, 16'hAAAA);
        send_request(KIND_DEQ_ANY, 16'h0001);   // a is oldest
        send_request(KIND_DEQ_ANY, 16'hFFFE);   // b is now oldest
        send_request(KIND_DEQ_ANY, 16'h8000);   // b again, older than a
        send_request(KIND_DEQ_B, 16'h7FFF);     // b empty
        send_request(KIND_DEQ_A, 16'h0000);
        send_request(KIND_DEQ_ANY, 16'hFFFF);   // both empty
    endtask

    // fill each class past its depth, then drain it past empty
    task automatic test_fifo_full;
        logic [KIND_W-1:0] enq_kind;
        logic [KIND_W-1:0] deq_kind;
        for (int c = 0; c < 2; c++)
        begin
            enq_kind = (c == 0) ? KIND_ENQ_A : KIND_ENQ_B;
            deq_kind = (c == 0) ? KIND_DEQ_A : KIND_DEQ_B;
            for (int i = 0; i < QD + 2; i++)
                send_request(enq_kind, any_tag());
            for (int i = 0; i < QD + 1; i++)
                send_request(deq_kind, any_tag());
        end
    endtask

    // both sides at full rate
    task automatic test_no_idle_stretch;
        idle_pct = 0;
        run_mix(300);
        idle_pct = IDLE_PCT;
    endtask

    // heads many arrivals apart in age, older head in either class
    task automatic test_age_gap;
        idle_pct = 0;
        while (class_count[CLASS_A] != 0)
            send_request(KIND_DEQ_A, any_tag());
        while (class_count[CLASS_B] != 0)
            send_request(KIND_DEQ_B, any_tag());
        // a entry well behind the b entry
        send_request(KIND_ENQ_A, any_tag());
        pump_sequence(arrival_seq + DEF_SEQ_BITS'(150));
        send_request(KIND_ENQ_B, any_tag());
        send_request(KIND_DEQ_ANY, any_tag());
        send_request(KIND_DEQ_ANY, any_tag());
        // b entry well behind the a entry
        send_request(KIND_ENQ_B, any_tag());
        pump_sequence(arrival_seq + DEF_SEQ_BITS'(100));
        send_request(KIND_ENQ_A, any_tag());
        send_request(KIND_DEQ_ANY, any_tag());
        send_request(KIND_DEQ_ANY, any_tag());
        idle_pct = IDLE_PCT;
        run_mix(80);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= KIND_ENQ_A;
        m_axis_tready  <= 1'b0;
        idle_pct       = IDLE_PCT;
        mismatch_count = 0;
        cycle_count    = 0;
        arrival_seq    = '0;
        for (int c = 0; c < 2; c++)
        begin
            class_head[c]  = 0;
            class_count[c] = 0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_dequeues;
        test_basic_order;
        test_fifo_full;
        run_mix(1150);
        test_no_idle_stretch;
        test_age_gap;
        s_axis_tvalid <= 1'b0;

        while (outcome_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && outcome_queue.size() == 0)
            $display("[two_class_age_ordered_queue] OK");
        else
            $display("[two_class_age_ordered_queue] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tcaoq_pkg.sv
rtl/tcaoq_fifo.sv
rtl/two_class_age_ordered_queue.sv
tb/tb.sv
